@@ rtl/core/dcm_pkg.sv @@
// Shared constants, codes and types of the depth colour map block.
package dcm_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int QUOT_BITS     = 8;
   localparam int COLOUR_BITS   = 24;
   localparam int MODE_BITS     = 2;
   localparam int SEL_BITS      = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [MODE_BITS-1:0] MODE_RAINBOW = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_GREY    = 2'd2;

   localparam logic [REG_IDX_BITS-1:0] REG_MODE       = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_RANGE_LOW  = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_RANGE_HIGH = 2'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_SAFETY     = 2'd3;

   // colour select codes carried down the divider chain
   localparam logic [SEL_BITS-1:0] SEL_WHITE = 3'd0;
   localparam logic [SEL_BITS-1:0] SEL_RED   = 3'd1;
   localparam logic [SEL_BITS-1:0] SEL_SEG0  = 3'd2;
   localparam logic [SEL_BITS-1:0] SEL_SEG1  = 3'd3;
   localparam logic [SEL_BITS-1:0] SEL_SEG2  = 3'd4;
   localparam logic [SEL_BITS-1:0] SEL_SEG3  = 3'd5;
   localparam logic [SEL_BITS-1:0] SEL_GREY  = 3'd6;

   localparam logic [QUOT_BITS-1:0]   CHAN_MAX   = 8'd255;
   localparam logic [QUOT_BITS-1:0]   CHAN_ZERO  = 8'd0;
   localparam logic [COLOUR_BITS-1:0] WHITE      = 24'hFFFFFF;
   localparam logic [COLOUR_BITS-1:0] SAFETY_RED = {8'd240, 8'd20, 8'd20};

   localparam logic [MODE_BITS-1:0]   MODE_RESET       = MODE_RAINBOW;
   localparam logic [SAMPLE_BITS-1:0] RANGE_LOW_RESET  = '0;
   localparam logic [SAMPLE_BITS-1:0] RANGE_HIGH_RESET = SAMPLE_BITS'(256);
   localparam logic [SAMPLE_BITS-1:0] SAFETY_RESET     = '0;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type           low;
      sample_type           high;
      sample_type           safety;
      logic [MODE_BITS-1:0] mode;
   } cfg_type;

   typedef struct packed {
      logic [SEL_BITS-1:0] sel;
      logic                empty;
   } ctl_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] rem;
      logic [QUOT_BITS-1:0]   low;
      logic [QUOT_BITS-1:0]   quot;
      logic [SAMPLE_BITS-1:0] den;
      ctl_type                ctl;
   } cell_type;

endpackage

@@ rtl/core/dcm_front.sv @@
// Front stages: clamp, segment select and dividend setup for the divider chain.
module dcm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  dcm_pkg::cfg_type          cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  dcm_pkg::sample_type       in_sample,
   output logic                      out_valid,
   input  logic                      out_ready,
   output dcm_pkg::cell_type         out_data
);

   localparam int SB = dcm_pkg::SAMPLE_BITS;
   localparam int QB = dcm_pkg::QUOT_BITS;

   logic                v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                adv1, adv2, adv3;
   dcm_pkg::sample_type vcl_ff, vcl_in;
   logic                red_ff, red_in;
   logic [SB-1:0]       num_ff, num_in;
   dcm_pkg::ctl_type    ctl_ff, ctl_in;
   dcm_pkg::cell_type   cell_ff, cell_in;

   logic [SB:0]         diff;
   logic [SB-1:0]       dv, d;
   logic [SB+1:0]       d4, dv_x1, dv_x2, dv_x3, dv_x4;
   logic [SB+1:0]       t_seg1, t_seg2, t_seg3;
   logic                empty, ramp;
   logic [SB+QB-1:0]    dividend;

   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   assign v1_in = adv1 ? in_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   // stage 1: clamp to the range, compare with the safety depth
   always_comb begin
      priority if (in_sample < cfg.low) begin
         vcl_in = cfg.low;
      end else if (in_sample > cfg.high) begin
         vcl_in = cfg.high;
      end else begin
         vcl_in = in_sample;
      end
      red_in = in_sample > cfg.safety;
   end

   // stage 2: position in the range picks the segment and the numerator
   assign diff   = {cfg.high[SB-1], cfg.high} - {cfg.low[SB-1], cfg.low};
   assign dv     = diff[SB-1:0];
   assign empty  = !(cfg.high > cfg.low);
   assign ramp   = (cfg.mode == dcm_pkg::MODE_RAINBOW) || (cfg.mode == dcm_pkg::MODE_GREY);
   assign d      = vcl_ff - cfg.low;
   assign d4     = {d, 2'b00};
   assign dv_x1  = {2'b00, dv};
   assign dv_x2  = {1'b0, dv, 1'b0};
   assign dv_x3  = dv_x1 + dv_x2;
   assign dv_x4  = {dv, 2'b00};
   assign t_seg1 = dv_x2 - d4;
   assign t_seg2 = d4 - dv_x2;
   assign t_seg3 = dv_x4 - d4;

   always_comb begin
      num_in       = '0;
      ctl_in.empty = 1'b0;
      ctl_in.sel   = dcm_pkg::SEL_WHITE;
      priority if (!ramp) begin
         ctl_in.sel = red_ff ? dcm_pkg::SEL_RED : dcm_pkg::SEL_WHITE;
      end else if (empty) begin
         ctl_in.empty = 1'b1;
      end else if (cfg.mode == dcm_pkg::MODE_GREY) begin
         ctl_in.sel = dcm_pkg::SEL_GREY;
         // at or past a quarter of the range the grey level saturates
         num_in     = (d4 < dv_x1) ? d4[SB-1:0] : dv;
      end else if (d4 < dv_x1) begin
         ctl_in.sel = dcm_pkg::SEL_SEG0;
         num_in     = d4[SB-1:0];
      end else if (d4 < dv_x2) begin
         ctl_in.sel = dcm_pkg::SEL_SEG1;
         num_in     = t_seg1[SB-1:0];
      end else if (d4 < dv_x3) begin
         ctl_in.sel = dcm_pkg::SEL_SEG2;
         num_in     = t_seg2[SB-1:0];
      end else begin
         ctl_in.sel = dcm_pkg::SEL_SEG3;
         num_in     = t_seg3[SB-1:0];
      end
   end

   // stage 3: dividend = num * 255, split into the head remainder and the low bits
   assign dividend = {num_ff, {QB{1'b0}}} - {{QB{1'b0}}, num_ff};

   always_comb begin
      cell_in.rem  = dividend[SB+QB-1:QB];
      cell_in.low  = dividend[QB-1:0];
      cell_in.quot = '0;
      cell_in.den  = dv;
      cell_in.ctl  = ctl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         vcl_ff <= vcl_in;
         red_ff <= red_in;
      end
      if (adv2) begin
         num_ff <= num_in;
         ctl_ff <= ctl_in;
      end
      if (adv3) begin
         cell_ff <= cell_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = cell_ff;

endmodule

@@ rtl/core/dcm_div_cell.sv @@
// One restoring divider cell: retires one quotient bit per transaction.
module dcm_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dcm_pkg::cell_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output dcm_pkg::cell_type out_data
);

   localparam int SB = dcm_pkg::SAMPLE_BITS;
   localparam int QB = dcm_pkg::QUOT_BITS;

   logic              valid_ff, valid_in;
   logic              adv;
   dcm_pkg::cell_type data_ff, data_in;
   logic [SB+1:0]     trial;
   logic              fits;

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;
   assign valid_in = adv ? in_valid : valid_ff;

   // shift in the next dividend bit and try to subtract the divisor
   assign trial = {1'b0, in_data.rem, in_data.low[QB-1]} - {2'b00, in_data.den};
   assign fits  = !trial[SB+1];

   always_comb begin
      data_in      = in_data;
      data_in.rem  = fits ? trial[SB-1:0] : {in_data.rem[SB-2:0], in_data.low[QB-1]};
      data_in.low  = {in_data.low[QB-2:0], 1'b0};
      data_in.quot = {in_data.quot[QB-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/core/dcm_pack.sv @@
// Output register: places the quotient into the selected colour channel.
module dcm_pack (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  dcm_pkg::cell_type                   in_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dcm_pkg::COLOUR_BITS-1:0]     rsp_colour,
   output logic                                rsp_empty_range
);

   logic                               valid_ff, valid_in;
   logic                               adv;
   logic [dcm_pkg::COLOUR_BITS-1:0]    colour_ff, colour_in;
   logic                               empty_ff;
   logic [dcm_pkg::QUOT_BITS-1:0]      q;

   assign adv      = !valid_ff || rsp_ready;
   assign in_ready = adv;
   assign valid_in = adv ? in_valid : valid_ff;
   assign q        = in_data.quot;

   always_comb begin
      unique case (in_data.ctl.sel)
         dcm_pkg::SEL_RED:  colour_in = dcm_pkg::SAFETY_RED;
         dcm_pkg::SEL_SEG0: colour_in = {dcm_pkg::CHAN_ZERO, q, dcm_pkg::CHAN_MAX};
         dcm_pkg::SEL_SEG1: colour_in = {dcm_pkg::CHAN_ZERO, dcm_pkg::CHAN_MAX, q};
         dcm_pkg::SEL_SEG2: colour_in = {q, dcm_pkg::CHAN_MAX, dcm_pkg::CHAN_ZERO};
         dcm_pkg::SEL_SEG3: colour_in = {dcm_pkg::CHAN_MAX, q, dcm_pkg::CHAN_ZERO};
         dcm_pkg::SEL_GREY: colour_in = {q, q, q};
         default:           colour_in = dcm_pkg::WHITE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         colour_ff <= colour_in;
         empty_ff  <= in_data.ctl.empty;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_colour      = colour_ff;
   assign rsp_empty_range = empty_ff;

endmodule

@@ rtl/core/depth_colour_map.sv @@
// Top level of the depth colour map: register file, front stages, divider chain, output.
//
//   channel  | direction | transaction moves
//   ---------+-----------+---------------------------------------------------
//   req_*    | in        | one depth sample (signed, 8 fraction bits)
//   rsp_*    | out       | packed RGB colour and the empty range flag
//   APB      | in/out    | one register write or read (mode, range, safety)
//
// Throughput is one transaction per clock unless the output stalls; a sample passes
// three front stages, eight divider cells (one quotient bit each) and output register.
// Every stage holds its own valid bit and advances whenever the stage after it
// is empty or moving, so bubbles close up and a stalled result does not stop
// intake while earlier stages have room. Reset is synchronous and clears the
// valid bits and the registers to their defaults.
module depth_colour_map (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [dcm_pkg::SAMPLE_BITS-1:0] req_depth_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dcm_pkg::COLOUR_BITS-1:0]       rsp_colour,
   output logic                                  rsp_empty_range,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [dcm_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  logic [dcm_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [dcm_pkg::CSR_DATA_BITS-1:0]     prdata,
   output logic                                  pready
);

   localparam int SB = dcm_pkg::SAMPLE_BITS;
   localparam int QB = dcm_pkg::QUOT_BITS;
   localparam int DW = dcm_pkg::CSR_DATA_BITS;

   // ---------------------------------------------------------------------
   // Register file. Writes land on the access cycle; reads are combinational.
   // ---------------------------------------------------------------------
   logic [dcm_pkg::MODE_BITS-1:0]    mode_ff, mode_in;
   dcm_pkg::sample_type              low_ff, low_in;
   dcm_pkg::sample_type              high_ff, high_in;
   dcm_pkg::sample_type              safety_ff, safety_in;
   logic                             wr_en;
   logic [dcm_pkg::REG_IDX_BITS-1:0] reg_idx;
   dcm_pkg::cfg_type                 cfg;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[dcm_pkg::CSR_ADDR_BITS-1:2];

   always_comb begin
      mode_in   = mode_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      safety_in = safety_ff;
      if (wr_en) begin
         unique case (reg_idx)
            dcm_pkg::REG_MODE:       mode_in   = pwdata[dcm_pkg::MODE_BITS-1:0];
            dcm_pkg::REG_RANGE_LOW:  low_in    = pwdata[SB-1:0];
            dcm_pkg::REG_RANGE_HIGH: high_in   = pwdata[SB-1:0];
            dcm_pkg::REG_SAFETY:     safety_in = pwdata[SB-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= dcm_pkg::MODE_RESET;
         low_ff    <= dcm_pkg::RANGE_LOW_RESET;
         high_ff   <= dcm_pkg::RANGE_HIGH_RESET;
         safety_ff <= dcm_pkg::SAFETY_RESET;
      end else begin
         mode_ff   <= mode_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         safety_ff <= safety_in;
      end
   end

   // read back: signed registers sign extended to the bus width
   always_comb begin
      unique case (reg_idx)
         dcm_pkg::REG_MODE:       prdata = DW'(mode_ff);
         dcm_pkg::REG_RANGE_LOW:  prdata = DW'(low_ff);
         dcm_pkg::REG_RANGE_HIGH: prdata = DW'(high_ff);
         dcm_pkg::REG_SAFETY:     prdata = DW'(safety_ff);
      endcase
   end

   // user must not change registers in flight (unenforced); front stages read them live
   assign cfg.low    = low_ff;
   assign cfg.high   = high_ff;
   assign cfg.safety = safety_ff;
   assign cfg.mode   = mode_ff;

   // ---------------------------------------------------------------------
   // Front stages: clamp, pick segment, build dividend num * 255.
   // ---------------------------------------------------------------------
   logic              chain_valid [QB+1];
   logic              chain_ready [QB+1];
   dcm_pkg::cell_type chain_data  [QB+1];

   dcm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_sample (req_depth_sample),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // ---------------------------------------------------------------------
   // Divider chain: each cell retires one quotient bit, MSB first, so the
   // channel value (num * 255) / range comes out of the last cell.
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < QB; i++) begin : g_cell
      dcm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   // ---------------------------------------------------------------------
   // Output register: place the quotient into the selected channel.
   // ---------------------------------------------------------------------
   dcm_pack u_pack (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (chain_valid[QB]),
      .in_ready        (chain_ready[QB]),
      .in_data         (chain_data[QB]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_colour      (rsp_colour),
      .rsp_empty_range (rsp_empty_range)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // an empty range always shows white
   a_empty_white : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_range |-> rsp_colour == dcm_pkg::WHITE)
      else $error("empty range result is not white");

   // the flag comes up only in the ramp modes
   a_empty_mode : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_range |->
         (mode_ff == dcm_pkg::MODE_RAINBOW) || (mode_ff == dcm_pkg::MODE_GREY))
      else $error("empty range flag outside a ramp mode");

   // two colour modes give only red or white
   a_two_colour : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_ff != dcm_pkg::MODE_RAINBOW) && (mode_ff != dcm_pkg::MODE_GREY) |->
         (rsp_colour == dcm_pkg::WHITE) || (rsp_colour == dcm_pkg::SAFETY_RED))
      else $error("two colour mode produced another colour");

   // every rainbow colour has one channel at full scale
   a_rainbow_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_ff == dcm_pkg::MODE_RAINBOW) |->
         (rsp_colour[23:16] == dcm_pkg::CHAN_MAX) || (rsp_colour[15:8] == dcm_pkg::CHAN_MAX) ||
         (rsp_colour[7:0] == dcm_pkg::CHAN_MAX))
      else $error("rainbow colour without a full channel");

endmodule

@@ sim/tb_depth_colour_map.sv @@
// Self-checking testbench of the depth colour map: directed and random samples over many settings.
module tb_depth_colour_map;
   import dcm_pkg::*;

   // two-colour mode codes; the package names only the ramp modes
   localparam logic [MODE_BITS-1:0] MODE_TWO_COLOUR_A = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_TWO_COLOUR_B = 2'd3;

   localparam longint SAMPLE_MAX    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN    = -(64'sd1 <<< (SAMPLE_BITS - 1));
   localparam int     CYCLE_LIMIT   = 500000;
   localparam int     DRAIN_CYCLES  = 16;
   localparam int     LONG_HOLD     = 400;
   localparam int     HOLD_AT_FIRST = 200;
   localparam int     HOLD_AT_LATER = 1000;
   localparam int     SHOW_LIMIT    = 10;

   typedef struct {
      logic [COLOUR_BITS-1:0] colour;
      logic                   empty_range;
   } pixel_t;

   typedef enum {RX_EAGER, RX_HALF, RX_SLOW, RX_TOGGLE} rx_style_e;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   sample_type                   req_depth_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [COLOUR_BITS-1:0]       rsp_colour;
   logic                         rsp_empty_range;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]     paddr = '0;
   logic [CSR_DATA_BITS-1:0]     pwdata = '0;
   logic [CSR_DATA_BITS-1:0]     prdata;
   logic                         pready;

   // shadow copy of the register file, updated as each write lands
   logic [MODE_BITS-1:0] cfg_mode   = MODE_RESET;
   sample_type           cfg_low    = RANGE_LOW_RESET;
   sample_type           cfg_high   = RANGE_HIGH_RESET;
   sample_type           cfg_safety = SAFETY_RESET;

   sample_type pending_samples[$];
   pixel_t     expected_pixels[$];

   int        mismatches   = 0;
   int        results_seen = 0;
   int        cycle_count  = 0;
   int        burst_left   = 16;
   int        gap_left     = 0;
   int        hold_left    = 0;
   int        style_left   = 0;
   rx_style_e rx_style     = RX_EAGER;

   depth_colour_map DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_depth_sample(req_depth_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_colour      (rsp_colour),
      .rsp_empty_range (rsp_empty_range),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // Colour prediction
   // ---------------------------------------------------------------------

   // one channel: floor(num * 255 / den), saturated at full scale
   function automatic logic [QUOT_BITS-1:0] scale_chan(longint num, longint den);
      longint q;
      q = (num * 255) / den;
      return (q > 255) ? CHAN_MAX : q[QUOT_BITS-1:0];
   endfunction

   function automatic pixel_t map_depth(sample_type depth);
      longint                 v, lo, hi, span, d4;
      logic [QUOT_BITS-1:0]   r, g, b;
      pixel_t                 px;
      v  = depth;
      lo = cfg_low;
      hi = cfg_high;
      px.empty_range = 1'b0;
      if (cfg_mode == MODE_RAINBOW || cfg_mode == MODE_GREY) begin
         if (hi <= lo) begin
            // empty range: white and flag
            px.colour      = WHITE;
            px.empty_range = 1'b1;
         end else begin
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            span = hi - lo;
            d4   = 4 * (v - lo);
            if (cfg_mode == MODE_GREY) begin
               g = scale_chan(d4, span);
               px.colour = {g, g, g};
            end else begin
               // pick the quarter segment of the blue-cyan-green-yellow-red ramp
               if (d4 < span) begin
                  r = CHAN_ZERO; g = scale_chan(d4, span); b = CHAN_MAX;
               end else if (d4 < 2 * span) begin
                  r = CHAN_ZERO; g = CHAN_MAX; b = scale_chan(2 * span - d4, span);
               end else if (d4 < 3 * span) begin
                  r = scale_chan(d4 - 2 * span, span); g = CHAN_MAX; b = CHAN_ZERO;
               end else begin
                  r = CHAN_MAX; g = scale_chan(4 * span - d4, span); b = CHAN_ZERO;
               end
               px.colour = {r, g, b};
            end
         end
      end else begin
         // two colour: red strictly deeper than the safety depth
         px.colour = (depth > cfg_safety) ? SAFETY_RED : WHITE;
      end
      return px;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic sample_type clamp_sample(longint x);
      if (x > SAMPLE_MAX) return sample_type'(SAMPLE_MAX);
      if (x < SAMPLE_MIN) return sample_type'(SAMPLE_MIN);
      return sample_type'(x);
   endfunction

   // draw a sample that lands mostly near the interesting points of the current setting
   function automatic sample_type pick_depth();
      longint lo, hi, span;
      lo   = cfg_low;
      hi   = cfg_high;
      span = hi - lo;
      case ($urandom_range(0, 9))
         0, 1: return sample_type'($urandom);
         2: begin
            case ($urandom_range(0, 5))
               0: return clamp_sample(lo + longint'($urandom_range(0, 2)) - 1);
               1: return clamp_sample(hi + longint'($urandom_range(0, 2)) - 1);
               2: return clamp_sample(longint'(cfg_safety) + longint'($urandom_range(0, 2)) - 1);
               default: begin
                  if (span <= 0) return clamp_sample(lo);
                  // hit the quarter boundaries and their neighbours
                  return clamp_sample(lo + (span * longint'($urandom_range(1, 3))) / 4
                                      + longint'($urandom_range(0, 2)) - 1);
               end
            endcase
         end
         default: begin
            if (cfg_mode != MODE_RAINBOW && cfg_mode != MODE_GREY)
               return clamp_sample(longint'(cfg_safety) + longint'($urandom_range(0, 128)) - 64);
            if (span <= 0)
               return clamp_sample(lo + longint'($urandom_range(0, 16)) - 8);
            return clamp_sample(lo - span / 8 + longint'($urandom_range(0, span + span / 4)));
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------

   // setup cycle, access cycle; the register lands on the access edge.
   // Upper data bits are random: only the low bits are meant to count.
   task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                            input logic [SAMPLE_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] word;
      word = $urandom;
      if (idx == REG_MODE)
         word[MODE_BITS-1:0] = value[MODE_BITS-1:0];
      else
         word[SAMPLE_BITS-1:0] = value;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_MODE:       cfg_mode   = value[MODE_BITS-1:0];
         REG_RANGE_LOW:  cfg_low    = value;
         REG_RANGE_HIGH: cfg_high   = value;
         REG_SAFETY:     cfg_safety = value;
         default: ;
      endcase
   endtask

   task automatic write_setting(input logic [MODE_BITS-1:0] mode, input longint lo,
                                input longint hi, input longint safety);
      write_reg(REG_MODE, SAMPLE_BITS'(mode));
      write_reg(REG_RANGE_LOW, clamp_sample(lo));
      write_reg(REG_RANGE_HIGH, clamp_sample(hi));
      write_reg(REG_SAFETY, clamp_sample(safety));
   endtask

   // pick a mode and a range; most spans are small so the quarter edges are dense
   task automatic write_random_setting();
      logic [MODE_BITS-1:0] mode;
      longint               lo, span, safety;
      int                   pick;
      pick = $urandom_range(0, 19);
      if (pick < 9)       mode = MODE_RAINBOW;
      else if (pick < 14) mode = MODE_GREY;
      else if (pick < 17) mode = MODE_TWO_COLOUR_A;
      else                mode = MODE_TWO_COLOUR_B;
      if ($urandom_range(0, 3) == 0) lo = sample_type'($urandom);
      else                           lo = longint'($urandom_range(0, 4000)) - 2000;
      case ($urandom_range(0, 9))
         0:       span = $urandom_range(1, 8);
         1, 2, 3: span = $urandom_range(9, 1024);
         4, 5, 6: span = $urandom_range(1025, 65536);
         7:       span = $urandom_range(65537, 16777215);
         8: begin
            lo   = SAMPLE_MIN;
            span = SAMPLE_MAX - SAMPLE_MIN;
         end
         default: span = -longint'($urandom_range(0, 300));   // empty range
      endcase
      if ($urandom_range(0, 3) == 0) safety = sample_type'($urandom);
      else                           safety = lo + longint'($urandom_range(0, 2000)) - 1000;
      write_setting(mode, lo, lo + span, safety);
   endtask

   // hold until the sender is drained and every expected result is back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic note_mismatch(input string what, input logic [COLOUR_BITS-1:0] want,
                                input logic [COLOUR_BITS-1:0] got);
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
         $display("mismatch on %s after %0d results: expected %h, got %h",
                  what, results_seen, want, got);
   endtask

   // ---------------------------------------------------------------------
   // Sender: bursts of random length with random gaps, payload held until taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict at acceptance; the setting cannot change while items are in flight
         if (req_valid && req_ready)
            expected_pixels.push_back(map_depth(req_depth_sample));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_valid        <= 1'b1;
               req_depth_sample <= pending_samples.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  // a quarter of the bursts run straight on with no gap
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver and checker: stall pattern of its own plus two long hold-offs
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               note_mismatch("unexpected result", '0, rsp_colour);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_colour !== want.colour)
                  note_mismatch("colour", want.colour, rsp_colour);
               if (rsp_empty_range !== want.empty_range)
                  note_mismatch("empty range flag", COLOUR_BITS'(want.empty_range),
                                COLOUR_BITS'(rsp_empty_range));
            end
            results_seen++;
            // back off long enough for the pipeline to fill and stall the input
            if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_LATER)
               hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               rx_style   = rx_style_e'($urandom_range(0, 3));
               style_left = $urandom_range(64, 256);
            end
            style_left--;
            case (rx_style)
               RX_EAGER:  rsp_ready <= 1'b1;
               RX_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SLOW:   rsp_ready <= ($urandom_range(0, 3) == 0);
               RX_TOGGLE: rsp_ready <= !rsp_ready;
               default:   rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // drop the run if it stops making progress
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL depth_colour_map");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int n_items;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset setting (rainbow over 0..1.0): clamps at both ends and quarter edges
      pending_samples = '{sample_type'(SAMPLE_MIN), 24'sd0, 24'sd63, 24'sd64, 24'sd127,
                          24'sd128, 24'sd192, 24'sd255, 24'sd256, sample_type'(SAMPLE_MAX)};
      wait_idle();

      // grey over the widest range: low end, mid point saturates, top end
      write_setting(MODE_GREY, SAMPLE_MIN, SAMPLE_MAX, 0);
      pending_samples = '{sample_type'(SAMPLE_MIN), 24'sd0, sample_type'(SAMPLE_MAX)};
      wait_idle();

      // empty range in both ramp modes: equal ends, then high below low
      write_setting(MODE_RAINBOW, 100, 100, 0);
      pending_samples = '{24'sd100, -24'sd5};
      wait_idle();
      write_setting(MODE_GREY, 100, -200, 0);
      pending_samples = '{24'sd0};
      wait_idle();

      // two colour: either side of the threshold, and equal to it
      write_setting(MODE_TWO_COLOUR_A, 0, 256, 0);
      pending_samples = '{24'sd0, 24'sd1, -24'sd1};
      wait_idle();
      write_setting(MODE_TWO_COLOUR_B, 0, 256, SAMPLE_MAX);
      pending_samples = '{sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MIN)};
      wait_idle();

      // random settings; the first phase is long so the first hold-off falls inside it
      for (int phase = 0; phase < 13; phase++) begin
         write_random_setting();
         n_items = (phase == 0) ? 400 : 95;
         repeat (n_items) pending_samples.push_back(pick_depth());
         wait_idle();
      end

      mismatches += expected_pixels.size();
      if (mismatches == 0)
         $display("PASS depth_colour_map");
      else
         $display("FAIL depth_colour_map");
      $finish;
   end

endmodule
